@@ rtl/sps_pkg.sv @@
// Shared types, constants and helpers for the servo pulse sequencer.
package sps_pkg;

    localparam int SLOTS     = 8;
    localparam int LINES     = 16;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int CH_W      = 4;
    localparam int WID_W     = 16;
    localparam int PIN_W     = 16;
    localparam int SUM_W     = WID_W + CNT_W;
    localparam int KIND_W    = 2;
    localparam int SLOT_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SLOT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd2;

    typedef enum logic {
        TOP_IDLE,
        TOP_COMMIT
    } top_state_t;

    typedef enum logic [1:0] {
        PK_IDLE,
        PK_WALK,
        PK_GAP,
        PK_DONE
    } pk_state_t;

    // schedule entry write from the packer into the pending schedule
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  channel;
        logic [WID_W-1:0] width;
    } sched_wr_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
        logic [WID_W-1:0] gap;
    } commit_res_t;

    typedef struct packed {
        logic tick;
        logic commit;
    } play_cmd_t;

    function automatic logic [PIN_W-1:0] line_bit(input logic [CH_W-1:0] ch);
        logic [PIN_W-1:0] b;
        b = '0;
        if (int'(ch) < LINES) begin
            b = PIN_W'(1) << ch;
        end
        return b;
    endfunction

endpackage

@@ rtl/sps_packer.sv @@
// Staging table and commit walker: one slot per cycle through a shared compare and adder.
module sps_packer
    import sps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              stage_we,
    input  logic [SLOT_W-1:0] stage_slot,
    input  logic              stage_used,
    input  logic [CH_W-1:0]   stage_channel,
    input  logic [WID_W-1:0]  stage_width,
    input  logic              start,
    input  logic [3:0]        count_in,
    input  logic [WID_W-1:0]  min_width,
    input  logic [WID_W-1:0]  sync_width,
    input  logic [WID_W-1:0]  frame_width,
    input  logic              ack,
    output sched_wr_t         wr,
    output commit_res_t       res
);

    pk_state_t        state_reg, state_next;
    logic             used_reg [SLOTS];
    logic [CH_W-1:0]  ch_reg   [SLOTS];
    logic [WID_W-1:0] wid_reg  [SLOTS];
    logic [CNT_W-1:0] e_reg, lim_reg, n_reg, cnt_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [WID_W-1:0] gap_reg;

    logic             walking;
    logic             pass;
    logic [IDX_W-1:0] e_idx;
    logic [SUM_W:0]   sum_sync;
    logic [CNT_W-1:0] lim_sat;

    assign e_idx    = e_reg[IDX_W-1:0];
    assign walking  = (state_reg == PK_WALK) && (e_reg != lim_reg);
    assign pass     = used_reg[e_idx] && (wid_reg[e_idx] >= min_width);
    assign sum_sync = {1'b0, sum_reg} + (SUM_W + 1)'(sync_width);
    assign lim_sat  = (int'(count_in) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(count_in);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            PK_IDLE: if (start) state_next = PK_WALK;
            PK_WALK: if (e_reg == lim_reg) state_next = PK_GAP;
            PK_GAP:  state_next = PK_DONE;
            PK_DONE: if (ack) state_next = PK_IDLE;
            default: state_next = PK_IDLE;
        endcase
    end

    always_comb begin
        wr.valid   = walking && pass;
        wr.idx     = n_reg[IDX_W-1:0];
        wr.channel = ch_reg[e_idx];
        wr.width   = wid_reg[e_idx];
        res.done   = (state_reg == PK_DONE);
        res.count  = cnt_reg;
        res.gap    = gap_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PK_IDLE;
            for (int i = 0; i < SLOTS; i++) begin
                used_reg[i] <= 1'b0;
                ch_reg[i]   <= '0;
                wid_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (stage_we) begin
                used_reg[IDX_W'(stage_slot)] <= stage_used;
                ch_reg[IDX_W'(stage_slot)]   <= stage_channel;
                wid_reg[IDX_W'(stage_slot)]  <= stage_width;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == PK_IDLE && start) begin
            e_reg   <= '0;
            n_reg   <= '0;
            sum_reg <= '0;
            lim_reg <= lim_sat;
        end else if (walking) begin
            e_reg <= e_reg + 1'b1;
            if (pass) begin
                n_reg   <= n_reg + 1'b1;
                sum_reg <= sum_reg + SUM_W'(wid_reg[e_idx]);
            end
        end
        if (state_reg == PK_GAP) begin
            // empty frame when nothing adds width
            if (sum_reg == '0) begin
                cnt_reg <= '0;
                gap_reg <= '0;
            end else begin
                cnt_reg <= n_reg;
                if (sum_sync >= (SUM_W + 1)'(frame_width)) begin
                    gap_reg <= sync_width;
                end else begin
                    gap_reg <= frame_width - sum_reg[WID_W-1:0];
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.valid |-> (int'(n_reg) < SLOTS))
        else $error("schedule write beyond slot count");
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == PK_WALK) |-> (e_reg <= lim_reg))
        else $error("walk index passed its limit");
`endif

endmodule

@@ rtl/sps_player.sv @@
// Schedule register file and frame player: pulse and gap timing, line levels, swap.
module sps_player
    import sps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  play_cmd_t         cmd,
    input  sched_wr_t         wr,
    input  commit_res_t       res,
    output logic [PIN_W-1:0]  levels_next,
    output logic              sync_next,
    output logic              running_next
);

    logic [CH_W-1:0]  sch_ch_reg  [2][SLOTS];
    logic [WID_W-1:0] sch_wid_reg [2][SLOTS];
    logic [CNT_W-1:0] count_reg [2];
    logic [WID_W-1:0] gap_reg   [2];
    logic             active_reg, pending_reg, running_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [WID_W-1:0] ticks_reg;
    logic [PIN_W-1:0] levels_reg;
    logic [CH_W-1:0]  cur_ch_reg;

    logic [CNT_W-1:0] count_next [2];
    logic [WID_W-1:0] gap_next   [2];
    logic             active_next, pending_next;
    logic [CNT_W-1:0] pos_next;
    logic [WID_W-1:0] ticks_next;
    logic [CH_W-1:0]  cur_ch_next;

    logic             a;
    logic             mid;
    logic [CNT_W-1:0] pos_inc;
    logic             rd_sel;
    logic [IDX_W-1:0] rd_idx;
    logic [CH_W-1:0]  rd_ch;
    logic [WID_W-1:0] rd_wid;

    assign a       = active_reg;
    assign mid     = (pos_reg != count_reg[a]);
    assign pos_inc = pos_reg + 1'b1;

    // one read port: pick the entry that may start on this beat
    always_comb begin
        if (cmd.commit) begin
            rd_sel = ~a;
            rd_idx = '0;
        end else if (mid) begin
            rd_sel = a;
            rd_idx = pos_inc[IDX_W-1:0];
        end else begin
            rd_sel = pending_reg ? ~a : a;
            rd_idx = '0;
        end
    end

    assign rd_ch  = sch_ch_reg[rd_sel][rd_idx];
    assign rd_wid = sch_wid_reg[rd_sel][rd_idx];

    always_comb begin
        count_next   = count_reg;
        gap_next     = gap_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        running_next = running_reg;
        pos_next     = pos_reg;
        ticks_next   = ticks_reg;
        levels_next  = levels_reg;
        cur_ch_next  = cur_ch_reg;
        sync_next    = 1'b0;
        if (cmd.commit) begin
            count_next[~a] = res.count;
            gap_next[~a]   = res.gap;
            pending_next   = 1'b0;
            if (running_reg) begin
                pending_next = 1'b1;
            end else if (res.count != '0) begin
                running_next = 1'b1;
                active_next  = ~a;
                pos_next     = '0;
                levels_next  = levels_reg | line_bit(rd_ch);
                ticks_next   = rd_wid;
                cur_ch_next  = rd_ch;
            end
        end else if (cmd.tick && running_reg) begin
            if (ticks_reg > WID_W'(1)) begin
                ticks_next = ticks_reg - 1'b1;
            end else if (mid) begin
                // end of a pulse: drop its line, then next pulse or the gap
                levels_next = levels_reg & ~line_bit(cur_ch_reg);
                if (pos_inc != count_reg[a]) begin
                    levels_next = levels_next | line_bit(rd_ch);
                    ticks_next  = rd_wid;
                    cur_ch_next = rd_ch;
                end else begin
                    ticks_next = gap_reg[a];
                end
                pos_next = pos_inc;
            end else begin
                pos_next  = '0;
                sync_next = 1'b1;
                if (pending_reg && count_reg[~a] == '0) begin
                    active_next  = ~a;
                    pending_next = 1'b0;
                    running_next = 1'b0;
                end else begin
                    if (pending_reg) begin
                        active_next  = ~a;
                        pending_next = 1'b0;
                    end
                    levels_next = levels_reg | line_bit(rd_ch);
                    ticks_next  = rd_wid;
                    cur_ch_next = rd_ch;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            gap_reg[0]   <= '0;
            gap_reg[1]   <= '0;
            active_reg   <= 1'b0;
            pending_reg  <= 1'b0;
            running_reg  <= 1'b0;
            pos_reg      <= '0;
            ticks_reg    <= '0;
            levels_reg   <= '0;
            cur_ch_reg   <= '0;
        end else begin
            count_reg    <= count_next;
            gap_reg      <= gap_next;
            active_reg   <= active_next;
            pending_reg  <= pending_next;
            running_reg  <= running_next;
            pos_reg      <= pos_next;
            ticks_reg    <= ticks_next;
            levels_reg   <= levels_next;
            cur_ch_reg   <= cur_ch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.valid) begin
            sch_ch_reg[~active_reg][wr.idx]  <= wr.channel;
            sch_wid_reg[~active_reg][wr.idx] <= wr.width;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_line: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(levels_reg))
        else $error("more than one line high");
    a_stopped_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (levels_reg == '0))
        else $error("line high while stopped");
    a_stop_on_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg && !running_next) |-> sync_next)
        else $error("stopped outside a frame end");
`endif

endmodule

@@ rtl/servo_pulse_sequencer_top.sv @@
// Servo pulse sequencer: stream ports, config registers, output register, sequencing.
// A tick, slot write or unknown beat gives its result beat in the cycle after accept.
// A commit walks the staged slots one per cycle in a shared compare/add unit, then sets the gap.
// Throughput: one tick or slot beat per cycle while the output is free; no input is taken during a commit walk.
// Reset: aresetn synchronous, active low; clears control, staging table, config to defaults.
// The schedule store holds no reset value; only entries written by a commit are read.
module servo_pulse_sequencer_top
    import sps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // slot[2:0], slot_used[3], channel[7:4],
                                            // pulse_width[23:8], slot_count[27:24]
    input  logic [KIND_W-1:0]    s_tuser,   // kind[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // pin_levels[15:0], frame_sync[16], running[17]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WID_W-1:0]     cfg_data
);

    top_state_t       state_reg, state_next;
    logic [WID_W-1:0] min_width_reg, sync_width_reg, frame_width_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [23:0]      m_tdata_reg;

    logic              out_free, in_acc, ack, out_load, pk_start, stage_we;
    logic [SLOT_W-1:0] in_slot;
    logic              in_used;
    logic [CH_W-1:0]   in_channel;
    logic [WID_W-1:0]  in_width;
    logic [3:0]        in_count;
    sched_wr_t         wr;
    commit_res_t       res;
    play_cmd_t         cmd;
    logic [PIN_W-1:0]  levels_next;
    logic              sync_next, running_next;

    assign in_slot    = s_tdata[2:0];
    assign in_used    = s_tdata[3];
    assign in_channel = s_tdata[7:4];
    assign in_width   = s_tdata[23:8];
    assign in_count   = s_tdata[27:24];

    assign out_free = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign ack      = res.done && out_free;
    assign pk_start = in_acc && (s_tuser == KIND_COMMIT);
    assign stage_we = in_acc && (s_tuser == KIND_SLOT) && (int'(in_slot) < SLOTS);
    assign out_load = (in_acc && (s_tuser != KIND_COMMIT)) || ack;
    assign cmd.tick   = in_acc && (s_tuser == KIND_TICK);
    assign cmd.commit = ack;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE:   if (pk_start) state_next = TOP_COMMIT;
            TOP_COMMIT: if (ack) state_next = TOP_IDLE;
            default:    state_next = TOP_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == TOP_IDLE) && out_free;
        cfg_ready     = 1'b1;
        m_tvalid      = m_tvalid_reg;
        m_tdata       = m_tdata_reg;
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    sps_packer u_packer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stage_we      (stage_we),
        .stage_slot    (in_slot),
        .stage_used    (in_used),
        .stage_channel (in_channel),
        .stage_width   (in_width),
        .start         (pk_start),
        .count_in      (in_count),
        .min_width     (min_width_reg),
        .sync_width    (sync_width_reg),
        .frame_width   (frame_width_reg),
        .ack           (ack),
        .wr            (wr),
        .res           (res)
    );

    sps_player u_player (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .wr           (wr),
        .res          (res),
        .levels_next  (levels_next),
        .sync_next    (sync_next),
        .running_next (running_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= TOP_IDLE;
            m_tvalid_reg    <= 1'b0;
            min_width_reg   <= WID_W'(500);
            sync_width_reg  <= WID_W'(3000);
            frame_width_reg <= WID_W'(20000);
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_WIDTH:   min_width_reg   <= cfg_data;
                    CFG_SYNC_WIDTH:  sync_width_reg  <= cfg_data;
                    CFG_FRAME_WIDTH: frame_width_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {6'd0, running_next, sync_next, levels_next};
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == TOP_COMMIT) |-> !s_tready)
        else $error("input taken during commit");
    a_done_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res.done |-> (state_reg == TOP_COMMIT))
        else $error("commit result while idle");
`endif

endmodule
